[rtl/fpalloc_pkg.sv]
// Shared constants, widths and status codes of the fixed-partition allocator.
package fpalloc_pkg;

   // Table depth and width of every size value.
   localparam int MAX_PARTITIONS = 16;
   localparam int SIZE_BITS      = 16;

   // Derived widths: slot index, counts that reach the depth itself, result index field.
   localparam int IDX_BITS  = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
   localparam int CNT_BITS  = $clog2(MAX_PARTITIONS + 1);
   localparam int PIDX_BITS = 4;
   localparam int STAT_BITS = 3;

   // Beat widths on the two stream sides.
   localparam int REQ_TDATA_BITS = ((SIZE_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = STAT_BITS + PIDX_BITS + 2 * SIZE_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // Reset value of the total memory size register.
   localparam logic [SIZE_BITS-1:0] TOTAL_RESET = SIZE_BITS'(65535);

   // Request kinds carried in tuser.
   localparam logic OP_DEFINE   = 1'b0;
   localparam logic OP_ALLOCATE = 1'b1;

   // Result status codes.
   localparam logic [STAT_BITS-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_BITS-1:0] ST_REJECTED = 3'd1;
   localparam logic [STAT_BITS-1:0] ST_NO_FIT   = 3'd2;
   localparam logic [STAT_BITS-1:0] ST_FULL     = 3'd3;
   localparam logic [STAT_BITS-1:0] ST_INVALID  = 3'd4;

endpackage

[rtl/fixed_partition_first_fit_allocator_unit.sv]
// Top level of the fixed-partition first-fit allocator: sequencer, table and result register.

// The block keeps a table of up to MAX_PARTITIONS fixed partitions. A define beat
// (tuser 0) appends a partition when the table has room and the placed sizes stay
// within total_size; an allocate beat (tuser 1) scans the placed partitions in index
// order with one shared compare and subtract unit and claims the first free one that
// is large enough. Each request beat yields exactly one response beat. An invalid,
// define, full or empty-table request passes from S_DECIDE straight to S_EMIT, where
// its response is loaded; an allocate steps through S_READ, which reads the
// partition-size RAM, and S_CHECK, which compares, for every entry it scans. While an
// earlier response still waits in the output register, S_EMIT holds, so response
// stalls lengthen each request. The block takes one request at a time and is ready
// again once the response is in the output register.
module fixed_partition_first_fit_allocator_unit
   import fpalloc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // Configuration: total_size in KB.
   input  logic                      csr_write_enable,
   input  logic [SIZE_BITS-1:0]      csr_write_data,
   // Request stream.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,  // [15:0] size
   input  logic                      req_tuser,  // [0] opcode
   // Response stream.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [2:0] status, [6:3] partition_index, [22:7] unplaced_space,
   // [38:23] internal_fragmentation, [39] zero
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DECIDE = 5'b00010,
      S_READ   = 5'b00100,
      S_CHECK  = 5'b01000,
      S_EMIT   = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   logic [SIZE_BITS-1:0]    total_ff, total_in;
   logic                    op_ff, op_in;
   logic [SIZE_BITS-1:0]    size_ff, size_in;
   logic [IDX_BITS-1:0]     idx_ff, idx_in;
   logic [STAT_BITS-1:0]    status_ff, status_in;
   logic [MAX_PARTITIONS-1:0] busy_ff, busy_in;
   logic [CNT_BITS-1:0]     placed_ff, placed_in;
   logic [CNT_BITS-1:0]     busy_count_ff, busy_count_in;
   logic [SIZE_BITS-1:0]    used_ff, used_in;
   logic [SIZE_BITS-1:0]    frag_ff, frag_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                    ram_we;
   logic [SIZE_BITS-1:0]    ram_rdata;
   logic [SIZE_BITS:0]      define_sum;
   logic                    define_fits;
   logic                    entry_fits;
   logic [SIZE_BITS-1:0]    leftover;
   logic [SIZE_BITS:0]      frag_sum;
   logic [CNT_BITS-1:0]     next_idx_count;
   logic [SIZE_BITS-1:0]    unplaced;
   logic                    rsp_slot_free;

   // Partition sizes; values of entries at or above the placed count are never used.
   fpalloc_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (MAX_PARTITIONS)
   ) u_size_ram (
      .clock        (clock),
      .write_enable (ram_we),
      .write_addr   (placed_ff[IDX_BITS-1:0]),
      .write_data   (size_ff),
      .read_addr    (idx_ff),
      .read_data    (ram_rdata)
   );

   // Shared arithmetic: placement check, size compare and fragmentation update.
   assign define_sum     = {1'b0, used_ff} + {1'b0, size_ff};
   assign define_fits    = (define_sum <= {1'b0, total_ff}) &&
                           (placed_ff < CNT_BITS'(MAX_PARTITIONS));
   assign entry_fits     = !busy_ff[idx_ff] && (ram_rdata >= size_ff);
   assign leftover       = ram_rdata - size_ff;
   assign frag_sum       = {1'b0, frag_ff} + {1'b0, leftover};
   assign next_idx_count = CNT_BITS'(idx_ff) + CNT_BITS'(1);
   assign unplaced       = (total_ff > used_ff) ? (total_ff - used_ff) : '0;
   assign rsp_slot_free  = !rsp_valid_ff || rsp_tready;

   // Sequencer and table updates.
   always_comb begin
      state_in      = state_ff;
      total_in      = csr_write_enable ? csr_write_data : total_ff;
      op_in         = op_ff;
      size_in       = size_ff;
      idx_in        = idx_ff;
      status_in     = status_ff;
      busy_in       = busy_ff;
      placed_in     = placed_ff;
      busy_count_in = busy_count_ff;
      used_in       = used_ff;
      frag_in       = frag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               size_in  = req_tdata[SIZE_BITS-1:0];
               idx_in   = '0;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_EMIT;
            if (size_ff == '0) begin
               status_in = ST_INVALID;
            end else if (op_ff == OP_DEFINE) begin
               if (define_fits) begin
                  ram_we                               = 1'b1;
                  busy_in[placed_ff[IDX_BITS-1:0]]     = 1'b0;
                  idx_in                               = placed_ff[IDX_BITS-1:0];
                  placed_in                            = placed_ff + CNT_BITS'(1);
                  used_in                              = define_sum[SIZE_BITS-1:0];
                  status_in                            = ST_OK;
               end else begin
                  status_in = ST_REJECTED;
               end
            end else if (placed_ff == '0) begin
               status_in = ST_NO_FIT;
            end else if (busy_count_ff >= placed_ff) begin
               status_in = ST_FULL;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (entry_fits) begin
               busy_in[idx_ff] = 1'b1;
               busy_count_in   = busy_count_ff + CNT_BITS'(1);
               frag_in         = frag_sum[SIZE_BITS] ? '1 : frag_sum[SIZE_BITS-1:0];
               status_in       = ST_OK;
               state_in        = S_EMIT;
            end else if (next_idx_count >= placed_ff) begin
               status_in = ST_NO_FIT;
               state_in  = S_EMIT;
            end else begin
               idx_in   = next_idx_count[IDX_BITS-1:0];
               state_in = S_READ;
            end
         end
         S_EMIT: begin
            if (rsp_slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_TDATA_BITS'({
                  frag_ff,
                  unplaced,
                  (status_ff == ST_OK) ? PIDX_BITS'(idx_ff) : PIDX_BITS'(0),
                  status_ff});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state with synchronous reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         total_ff      <= TOTAL_RESET;
         busy_ff       <= '0;
         placed_ff     <= '0;
         busy_count_ff <= '0;
         used_ff       <= '0;
         frag_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         busy_ff       <= busy_in;
         placed_ff     <= placed_in;
         busy_count_ff <= busy_count_in;
         used_ff       <= used_in;
         frag_ff       <= frag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Request fields, scan position and result payload.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      size_ff     <= size_in;
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The busy count tracks the busy flags.
   assert property (@(posedge clock) disable iff (reset)
      $countones(busy_ff) == 32'(busy_count_ff))
      else $error("busy count differs from busy flags");

   // No more partitions busy than placed, and the table never overflows.
   assert property (@(posedge clock) disable iff (reset)
      (busy_count_ff <= placed_ff) && (placed_ff <= CNT_BITS'(MAX_PARTITIONS)))
      else $error("partition counts out of range");

   // The scan only visits placed partitions.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ || state_ff == S_CHECK) |-> (CNT_BITS'(idx_ff) < placed_ff))
      else $error("scan index beyond placed partitions");

   // A successful allocation leaves the chosen partition marked busy.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && entry_fits) |=> busy_ff[$past(idx_ff)])
      else $error("allocated partition not marked busy");

endmodule

[rtl/fpalloc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module fpalloc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        write_enable,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] write_addr,
   input  logic [WIDTH-1:0]                            write_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] read_addr,
   output logic [WIDTH-1:0]                            read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule
